[sv/vfga_pkg.sv]
package vfga_pkg;

    // Grid geometry and accumulator width.
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int ACC_WIDTH   = 24;

    localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int Q_W        = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    // Fixed field widths.
    localparam int SIZE_W    = 10;
    localparam int GRID_W    = 7;
    localparam int POINT_W   = 16;
    localparam int VEC_IN_W  = 16;
    localparam int VEC_OUT_W = 24;
    localparam int FIELD_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = SIZE_W;

    // Divider: two quotient bits per cycle.
    localparam int REM_W      = (POINT_W > SIZE_W + Q_W) ? POINT_W : SIZE_W + Q_W;
    localparam int DIV_STEPS  = (Q_W + 1) / 2;
    localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Queues.
    localparam int JOBQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_WIDTH   = 2'd0,
        CFG_CELL_HEIGHT  = 2'd1,
        CFG_GRID_COLUMNS = 2'd2,
        CFG_GRID_ROWS    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RMW
    } t_bk_state;

    typedef struct packed {
        logic [1:0]                  operation;
        logic signed [POINT_W-1:0]   point_x;
        logic signed [POINT_W-1:0]   point_y;
        logic signed [VEC_IN_W-1:0]  add_x;
        logic signed [VEC_IN_W-1:0]  add_y;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0]          cell_column;
        logic [FIELD_W-1:0]          cell_row;
        logic signed [VEC_OUT_W-1:0] vector_x;
        logic signed [VEC_OUT_W-1:0] vector_y;
        logic                        saturated;
    } t_result;

    typedef struct packed {
        logic [SIZE_W-1:0] cell_width;
        logic [SIZE_W-1:0] cell_height;
        logic [GRID_W-1:0] grid_columns;
        logic [GRID_W-1:0] grid_rows;
    } t_cfg;

    typedef struct packed {
        logic                       is_clear;
        logic                       is_add;
        logic [COL_W-1:0]           col;
        logic [ROW_W-1:0]           row;
        logic signed [VEC_IN_W-1:0] add_x;
        logic signed [VEC_IN_W-1:0] add_y;
    } t_job;

endpackage

[sv/vector_field_grid_accumulator_unit.sv]
// Grid of 64 x 64 two-dimensional Q16.8 accumulators addressed by pixel point.
// A request enters through push/full and its result leaves through empty/pop,
// one result per request. The front end maps the point to a cell with a
// radix-4 divider (divide steps, then a hand-off state that can overlap the
// next accept); a two-entry queue feeds the back end, which handles an add or
// read as a registered memory read, then a result with a saturating write-back
// for an add, and holds up to two finished results. A clear request sweeps
// the store one cell per cycle through all 4096 cells before its result appears.
// After reset the same clearing pass runs and full stays high until it is done;
// configuration writes are taken at any time.
module vector_field_grid_accumulator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  vfga_pkg::t_item                   i_item,
    output logic                              empty,
    input  logic                              pop,
    output vfga_pkg::t_result                 o_result,
    input  logic                              i_cfg_wen,
    input  logic [vfga_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vfga_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    vfga_pkg::t_cfg r_cfg;
    logic           hold;
    logic           job_push, job_full, job_pop, job_empty;
    vfga_pkg::t_job front_job, queue_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_width <= vfga_pkg::SIZE_W'(16);
            r_cfg.cell_height <= vfga_pkg::SIZE_W'(16);
            r_cfg.grid_columns <= vfga_pkg::GRID_W'(64);
            r_cfg.grid_rows <= vfga_pkg::GRID_W'(64);
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                vfga_pkg::CFG_CELL_WIDTH: begin
                    r_cfg.cell_width <= i_cfg_wdata[vfga_pkg::SIZE_W-1:0];
                end
                vfga_pkg::CFG_CELL_HEIGHT: begin
                    r_cfg.cell_height <= i_cfg_wdata[vfga_pkg::SIZE_W-1:0];
                end
                vfga_pkg::CFG_GRID_COLUMNS: begin
                    r_cfg.grid_columns <= i_cfg_wdata[vfga_pkg::GRID_W-1:0];
                end
                vfga_pkg::CFG_GRID_ROWS: begin
                    r_cfg.grid_rows <= i_cfg_wdata[vfga_pkg::GRID_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    vfga_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_hold     (hold),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (front_job),
        .i_job_full (job_full)
    );

    vfga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (queue_job),
        .o_empty (job_empty)
    );

    vfga_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (queue_job),
        .o_job_pop   (job_pop),
        .o_hold      (hold),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

[sv/vfga_front.sv]
module vfga_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vfga_pkg::t_cfg  i_cfg,
    input  logic            i_hold,
    input  logic            i_push,
    input  vfga_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_job_push,
    output vfga_pkg::t_job  o_job,
    input  logic            i_job_full
);

    vfga_pkg::t_fe_state              r_state, n_state;
    logic [vfga_pkg::STEP_W-1:0]      r_cnt, n_cnt;
    logic [vfga_pkg::REM_W-1:0]       r_rem_x, n_rem_x, r_rem_y, n_rem_y;
    logic [vfga_pkg::Q_W-1:0]         r_q_x, n_q_x, r_q_y, n_q_y;
    logic                             r_ovf_x, n_ovf_x, r_ovf_y, n_ovf_y;
    logic [vfga_pkg::SIZE_W-1:0]      r_dv_x, n_dv_x, r_dv_y, n_dv_y;
    logic [vfga_pkg::COL_W-1:0]       r_lim_x, n_lim_x;
    logic [vfga_pkg::ROW_W-1:0]       r_lim_y, n_lim_y;
    logic                             r_is_clear, n_is_clear, r_is_add, n_is_add;
    logic signed [vfga_pkg::VEC_IN_W-1:0] r_add_x, n_add_x, r_add_y, n_add_y;

    logic                             accept;
    logic [vfga_pkg::REM_W-1:0]       rx, ry;
    logic [vfga_pkg::Q_W-1:0]         qx, qy;
    logic [vfga_pkg::REM_W:0]         sx, sy;
    logic [vfga_pkg::SIZE_W-1:0]      dvx, dvy;
    int                               effx, effy, k;

    // One restoring step: subtract the shifted divisor when it fits.
    function automatic logic [vfga_pkg::REM_W:0] div_bit(
        input logic [vfga_pkg::REM_W-1:0]  rem,
        input logic [vfga_pkg::SIZE_W-1:0] dv,
        input int                          sh
    );
        logic [vfga_pkg::REM_W-1:0] t;
        t = vfga_pkg::REM_W'(dv) << sh;
        if (rem >= t) begin
            return {rem - t, 1'b1};
        end
        return {rem, 1'b0};
    endfunction

    always_comb begin
        o_full = i_hold
              || !((r_state == vfga_pkg::FE_IDLE)
                || (r_state == vfga_pkg::FE_PUSH && !i_job_full));
        o_job_push = (r_state == vfga_pkg::FE_PUSH) && !i_job_full;
        accept = i_push && !o_full;

        o_job.is_clear = r_is_clear;
        o_job.is_add   = r_is_add;
        o_job.add_x    = r_add_x;
        o_job.add_y    = r_add_y;
        o_job.col = (r_ovf_x || r_q_x > vfga_pkg::Q_W'(r_lim_x))
                  ? r_lim_x : vfga_pkg::COL_W'(r_q_x);
        o_job.row = (r_ovf_y || r_q_y > vfga_pkg::Q_W'(r_lim_y))
                  ? r_lim_y : vfga_pkg::ROW_W'(r_q_y);
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_rem_x = r_rem_x;
        n_rem_y = r_rem_y;
        n_q_x = r_q_x;
        n_q_y = r_q_y;
        n_ovf_x = r_ovf_x;
        n_ovf_y = r_ovf_y;
        n_dv_x = r_dv_x;
        n_dv_y = r_dv_y;
        n_lim_x = r_lim_x;
        n_lim_y = r_lim_y;
        n_is_clear = r_is_clear;
        n_is_add = r_is_add;
        n_add_x = r_add_x;
        n_add_y = r_add_y;
        rx = r_rem_x;
        ry = r_rem_y;
        qx = r_q_x;
        qy = r_q_y;
        sx = '0;
        sy = '0;
        k = 0;
        dvx = (i_cfg.cell_width == '0) ? vfga_pkg::SIZE_W'(1) : i_cfg.cell_width;
        dvy = (i_cfg.cell_height == '0) ? vfga_pkg::SIZE_W'(1) : i_cfg.cell_height;
        effx = (i_cfg.grid_columns == '0) ? 1 : int'(i_cfg.grid_columns);
        effy = (i_cfg.grid_rows == '0) ? 1 : int'(i_cfg.grid_rows);
        if (effx > vfga_pkg::MAX_COLUMNS) begin
            effx = vfga_pkg::MAX_COLUMNS;
        end
        if (effy > vfga_pkg::MAX_ROWS) begin
            effy = vfga_pkg::MAX_ROWS;
        end

        case (r_state)
            vfga_pkg::FE_IDLE: begin
                if (accept) begin
                    n_state = vfga_pkg::FE_DIV;
                end
            end
            vfga_pkg::FE_DIV: begin
                for (int j = 0; j < 2; j++) begin
                    k = vfga_pkg::Q_W - 1 - 2 * int'(r_cnt) - j;
                    if (k >= 0) begin
                        sx = div_bit(rx, r_dv_x, k);
                        sy = div_bit(ry, r_dv_y, k);
                        rx = sx[vfga_pkg::REM_W:1];
                        ry = sy[vfga_pkg::REM_W:1];
                        qx = (qx << 1) | vfga_pkg::Q_W'(sx[0]);
                        qy = (qy << 1) | vfga_pkg::Q_W'(sy[0]);
                    end
                end
                n_rem_x = rx;
                n_rem_y = ry;
                n_q_x = qx;
                n_q_y = qy;
                if (r_cnt == vfga_pkg::STEP_W'(vfga_pkg::DIV_STEPS - 1)) begin
                    n_state = vfga_pkg::FE_PUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            vfga_pkg::FE_PUSH: begin
                if (!i_job_full) begin
                    n_state = accept ? vfga_pkg::FE_DIV : vfga_pkg::FE_IDLE;
                end
            end
            default: begin
                n_state = vfga_pkg::FE_IDLE;
            end
        endcase

        // Negative points land in cell 0; points past the last quotient bit
        // are flagged as overflow and clamp to the last cell.
        if (accept) begin
            n_cnt = '0;
            n_dv_x = dvx;
            n_dv_y = dvy;
            n_lim_x = vfga_pkg::COL_W'(effx - 1);
            n_lim_y = vfga_pkg::ROW_W'(effy - 1);
            n_q_x = '0;
            n_q_y = '0;
            n_rem_x = i_item.point_x[vfga_pkg::POINT_W-1]
                    ? '0 : vfga_pkg::REM_W'($unsigned(i_item.point_x));
            n_rem_y = i_item.point_y[vfga_pkg::POINT_W-1]
                    ? '0 : vfga_pkg::REM_W'($unsigned(i_item.point_y));
            n_ovf_x = n_rem_x >= (vfga_pkg::REM_W'(dvx) << vfga_pkg::Q_W);
            n_ovf_y = n_rem_y >= (vfga_pkg::REM_W'(dvy) << vfga_pkg::Q_W);
            n_is_clear = i_item.operation == vfga_pkg::OP_CLEAR;
            n_is_add = i_item.operation == vfga_pkg::OP_ADD;
            n_add_x = i_item.add_x;
            n_add_y = i_item.add_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfga_pkg::FE_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_x <= n_rem_x;
        r_rem_y <= n_rem_y;
        r_q_x <= n_q_x;
        r_q_y <= n_q_y;
        r_ovf_x <= n_ovf_x;
        r_ovf_y <= n_ovf_y;
        r_dv_x <= n_dv_x;
        r_dv_y <= n_dv_y;
        r_lim_x <= n_lim_x;
        r_lim_y <= n_lim_y;
        r_is_clear <= n_is_clear;
        r_is_add <= n_is_add;
        r_add_x <= n_add_x;
        r_add_y <= n_add_y;
    end

endmodule

[sv/vfga_queue.sv]
module vfga_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vfga_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output vfga_pkg::t_job o_job,
    output logic           o_empty
);

    vfga_pkg::t_job              r_slot [vfga_pkg::JOBQ_DEPTH];
    logic [vfga_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [vfga_pkg::QCNT_W-1:0] r_cnt;
    logic                        do_push, do_pop;

    always_comb begin
        o_full = r_cnt == vfga_pkg::QCNT_W'(vfga_pkg::JOBQ_DEPTH);
        o_empty = r_cnt == '0;
        o_job = r_slot[r_rp];
        do_push = i_push && !o_full;
        do_pop = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + vfga_pkg::QCNT_W'(do_push) - vfga_pkg::QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

[sv/vfga_back.sv]
module vfga_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  vfga_pkg::t_job    i_job,
    output logic              o_job_pop,
    output logic              o_hold,
    input  logic              i_pop,
    output logic              o_empty,
    output vfga_pkg::t_result o_result
);

    localparam int AW = vfga_pkg::ACC_WIDTH;

    logic [2*AW-1:0]              r_mem [vfga_pkg::CELL_COUNT];
    logic [2*AW-1:0]              r_rdata;

    vfga_pkg::t_bk_state          r_state, n_state;
    logic [vfga_pkg::ADDR_W-1:0]  r_clr_idx, n_clr_idx;
    logic                         r_init, n_init;
    vfga_pkg::t_job               r_job, n_job;
    logic [vfga_pkg::ADDR_W-1:0]  r_addr, n_addr;

    vfga_pkg::t_result            r_out [vfga_pkg::OUTQ_DEPTH];
    logic [vfga_pkg::QPTR_W-1:0]  r_out_wp, r_out_rp;
    logic [vfga_pkg::QCNT_W-1:0]  r_out_cnt;

    logic                         take, do_pop, push_res;
    vfga_pkg::t_result            res;
    logic [vfga_pkg::ADDR_W-1:0]  job_addr;
    logic                         mem_we;
    logic [vfga_pkg::ADDR_W-1:0]  mem_waddr;
    logic [2*AW-1:0]              mem_wdata;
    logic signed [AW-1:0]         old_x, old_y, new_x, new_y;
    logic signed [AW:0]           sum_x, sum_y;
    logic                         clip_x, clip_y;

    localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    function automatic logic [vfga_pkg::VEC_OUT_W-1:0] to_out(input logic signed [AW-1:0] v);
        logic signed [31:0] e;
        e = 32'(v);
        return e[vfga_pkg::VEC_OUT_W-1:0];
    endfunction

    always_comb begin
        n_state = r_state;
        n_clr_idx = r_clr_idx;
        n_init = r_init;
        n_job = r_job;
        n_addr = r_addr;
        mem_we = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        push_res = 1'b0;
        res = '0;

        job_addr = vfga_pkg::ADDR_W'(vfga_pkg::ADDR_W'(i_job.row)
                 * vfga_pkg::ADDR_W'(vfga_pkg::MAX_COLUMNS)
                 + vfga_pkg::ADDR_W'(i_job.col));
        take = (r_state == vfga_pkg::BK_IDLE) && !i_job_empty
            && (r_out_cnt != vfga_pkg::QCNT_W'(vfga_pkg::OUTQ_DEPTH));
        o_job_pop = take;
        o_hold = r_init;

        old_x = r_rdata[2*AW-1:AW];
        old_y = r_rdata[AW-1:0];
        sum_x = (AW+1)'(old_x) + (AW+1)'(r_job.add_x);
        sum_y = (AW+1)'(old_y) + (AW+1)'(r_job.add_y);
        clip_x = sum_x[AW] != sum_x[AW-1];
        clip_y = sum_y[AW] != sum_y[AW-1];
        new_x = clip_x ? (sum_x[AW] ? ACC_MIN : ACC_MAX) : sum_x[AW-1:0];
        new_y = clip_y ? (sum_y[AW] ? ACC_MIN : ACC_MAX) : sum_y[AW-1:0];

        case (r_state)
            vfga_pkg::BK_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == vfga_pkg::ADDR_W'(vfga_pkg::CELL_COUNT - 1)) begin
                    n_state = vfga_pkg::BK_IDLE;
                    n_init = 1'b0;
                    // The pass after reset answers no request.
                    push_res = !r_init;
                end
            end
            vfga_pkg::BK_IDLE: begin
                if (take) begin
                    n_job = i_job;
                    n_addr = job_addr;
                    if (i_job.is_clear) begin
                        n_state = vfga_pkg::BK_CLEAR;
                        n_clr_idx = '0;
                    end else begin
                        n_state = vfga_pkg::BK_RMW;
                    end
                end
            end
            vfga_pkg::BK_RMW: begin
                mem_we = r_job.is_add;
                mem_wdata = {new_x, new_y};
                push_res = 1'b1;
                res.cell_column = vfga_pkg::FIELD_W'(r_job.col);
                res.cell_row = vfga_pkg::FIELD_W'(r_job.row);
                res.vector_x = r_job.is_add ? to_out(new_x) : to_out(old_x);
                res.vector_y = r_job.is_add ? to_out(new_y) : to_out(old_y);
                res.saturated = r_job.is_add && (clip_x || clip_y);
                n_state = vfga_pkg::BK_IDLE;
            end
            default: begin
                n_state = vfga_pkg::BK_IDLE;
            end
        endcase

        o_empty = r_out_cnt == '0;
        o_result = r_out[r_out_rp];
        do_pop = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[job_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfga_pkg::BK_CLEAR;
            r_clr_idx <= '0;
            r_init <= 1'b1;
            r_out_wp <= '0;
            r_out_rp <= '0;
            r_out_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_clr_idx <= n_clr_idx;
            r_init <= n_init;
            if (push_res) begin
                r_out_wp <= r_out_wp + 1'b1;
            end
            if (do_pop) begin
                r_out_rp <= r_out_rp + 1'b1;
            end
            r_out_cnt <= r_out_cnt + vfga_pkg::QCNT_W'(push_res)
                       - vfga_pkg::QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_addr <= n_addr;
        if (push_res) begin
            r_out[r_out_wp] <= res;
        end
    end

endmodule

[sv/vfga_checker.sv]
module vfga_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input vfga_pkg::t_result o_result
);

    localparam logic [vfga_pkg::VEC_OUT_W-1:0] V_MAX =
        vfga_pkg::VEC_OUT_W'((64'sd1 <<< (vfga_pkg::ACC_WIDTH - 1)) - 64'sd1);
    localparam logic [vfga_pkg::VEC_OUT_W-1:0] V_MIN =
        vfga_pkg::VEC_OUT_W'(-(64'sd1 <<< (vfga_pkg::ACC_WIDTH - 1)));

    // Reset empties the result side and blocks requests for the clearing pass.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("result pending or input open right after reset");

    a_result_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result vanished without pop");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_result))
        else $error("waiting result changed without pop");

    // A clipped add leaves at least one component at a rail.
    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.saturated |->
            (o_result.vector_x == V_MAX || o_result.vector_x == V_MIN
          || o_result.vector_y == V_MAX || o_result.vector_y == V_MIN))
        else $error("saturated result without a component at a rail");

endmodule

bind vector_field_grid_accumulator_unit vfga_checker u_vfga_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int SAT_HI = (1 << (vfga_pkg::ACC_WIDTH - 1)) - 1;
    localparam int SAT_LO = -SAT_HI - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    vfga_pkg::t_item item_in = '0;
    logic empty;
    logic pop = 1'b0;
    vfga_pkg::t_result result_out;
    logic cfg_wen = 1'b0;
    logic [vfga_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [vfga_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Local copy of the grid and of the register settings.
    int cell_x [vfga_pkg::CELL_COUNT];
    int cell_y [vfga_pkg::CELL_COUNT];
    int unsigned cfg_cell_w = 16;
    int unsigned cfg_cell_h = 16;
    int unsigned cfg_cols = 64;
    int unsigned cfg_rows = 64;

    vfga_pkg::t_result pending_results[$];
    vfga_pkg::t_result want;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic holding = 1'b0;
    event hold_off_ev;

    vector_field_grid_accumulator_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_item      (item_in),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result_out),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int unsigned point_to_cell(input int p, input int unsigned size,
                                                  input int unsigned count,
                                                  input int unsigned limit);
        int unsigned div;
        int unsigned n;
        int unsigned q;
        div = (size == 0) ? 1 : size;
        n = (count == 0) ? 1 : count;
        if (n > limit) n = limit;
        if (p < 0) return 0;
        q = p / div;
        return (q > n - 1) ? n - 1 : q;
    endfunction

    function automatic int accumulate(input int acc, input int add, inout bit clip);
        int s;
        s = acc + add;
        if (s > SAT_HI) begin
            clip = 1'b1;
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            clip = 1'b1;
            s = SAT_LO;
        end
        return s;
    endfunction

    // Applies one request to the local grid and returns the result it should produce.
    function automatic vfga_pkg::t_result grid_apply(input vfga_pkg::t_item it);
        vfga_pkg::t_result r;
        int unsigned col;
        int unsigned row;
        int unsigned cell_idx;
        bit clip;
        r = '0;
        clip = 1'b0;
        if (it.operation == vfga_pkg::OP_CLEAR) begin
            cell_x = '{default: 0};
            cell_y = '{default: 0};
            return r;
        end
        col = point_to_cell(int'(it.point_x), cfg_cell_w, cfg_cols, vfga_pkg::MAX_COLUMNS);
        row = point_to_cell(int'(it.point_y), cfg_cell_h, cfg_rows, vfga_pkg::MAX_ROWS);
        cell_idx = row * vfga_pkg::MAX_COLUMNS + col;
        if (it.operation == vfga_pkg::OP_ADD) begin
            cell_x[cell_idx] = accumulate(cell_x[cell_idx], int'(it.add_x), clip);
            cell_y[cell_idx] = accumulate(cell_y[cell_idx], int'(it.add_y), clip);
        end
        r.cell_column = col[vfga_pkg::FIELD_W-1:0];
        r.cell_row = row[vfga_pkg::FIELD_W-1:0];
        r.vector_x = cell_x[cell_idx][vfga_pkg::VEC_OUT_W-1:0];
        r.vector_y = cell_y[cell_idx][vfga_pkg::VEC_OUT_W-1:0];
        r.saturated = clip;
        return r;
    endfunction

    function automatic vfga_pkg::t_item make_request(input logic [1:0] op, input int px,
                                                     input int py, input int ax,
                                                     input int ay);
        vfga_pkg::t_item it;
        it.operation = op;
        it.point_x = vfga_pkg::POINT_W'(px);
        it.point_y = vfga_pkg::POINT_W'(py);
        it.add_x = vfga_pkg::VEC_IN_W'(ax);
        it.add_y = vfga_pkg::VEC_IN_W'(ay);
        return it;
    endfunction

    // Mostly points that land inside the grid in use, with some negative and wild ones.
    function automatic int random_coord(input int unsigned size, input int unsigned count);
        int unsigned eff;
        int unsigned n;
        int unsigned span;
        eff = (size == 0) ? 1 : size;
        n = (count == 0) ? 1 : ((count > 64) ? 64 : count);
        span = eff * n + eff;
        if (span > 32767) span = 32767;
        case ($urandom_range(0, 9))
            0: return -int'($urandom_range(1, 32768));
            1: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, span));
        endcase
    endfunction

    function automatic int random_vector_part();
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 512)) - 256;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic vfga_pkg::t_item random_request(input int clear_pct);
        int pick;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < clear_pct) op = vfga_pkg::OP_CLEAR;
        else if (pick < 55) op = vfga_pkg::OP_ADD;
        else if (pick < 90) op = vfga_pkg::OP_READ;
        else op = OP_UNUSED;
        return make_request(op, random_coord(cfg_cell_w, cfg_cols),
                            random_coord(cfg_cell_h, cfg_rows),
                            random_vector_part(), random_vector_part());
    endfunction

    function automatic void compare_field(input string name, input int exp_val,
                                          input int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatch_count++;
        end
    endfunction

    task automatic program_grid(input int unsigned cw, input int unsigned ch,
                                input int unsigned cols, input int unsigned rows);
        cfg_wen <= 1'b1;
        cfg_idx <= vfga_pkg::CFG_CELL_WIDTH;
        cfg_wdata <= cw[vfga_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_idx <= vfga_pkg::CFG_CELL_HEIGHT;
        cfg_wdata <= ch[vfga_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_idx <= vfga_pkg::CFG_GRID_COLUMNS;
        cfg_wdata <= cols[vfga_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_idx <= vfga_pkg::CFG_GRID_ROWS;
        cfg_wdata <= rows[vfga_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        cfg_cell_w = cw & 32'h3FF;
        cfg_cell_h = ch & 32'h3FF;
        cfg_cols = cols & 32'h7F;
        cfg_rows = rows & 32'h7F;
    endtask

    // Offers one request and records its expected result once it is taken.
    task automatic send_item(input vfga_pkg::t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item_in <= it;
        do @(posedge clk); while (full);
        pending_results.push_back(grid_apply(it));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_item(make_request(vfga_pkg::OP_READ, 0, 0, 0, 0));
        send_item(make_request(vfga_pkg::OP_READ, -32768, -32768, 0, 0));
        send_item(make_request(vfga_pkg::OP_READ, 32767, 32767, -1, -1));
        wait_idle();
    endtask

    task automatic test_point_mapping();
        program_grid(1023, 1, 64, 64);
        send_item(make_request(vfga_pkg::OP_ADD, 5122, 40, 32767, -32768));
        send_item(make_request(vfga_pkg::OP_READ, 5122, 40, 0, 0));
        send_item(make_request(OP_UNUSED, 6022, 40, 0, 0));
        send_item(make_request(vfga_pkg::OP_ADD, -1, 100, -32768, 32767));
        wait_idle();
        // Zero sizes act as one, a zero column count as one column, and oversize counts as the maximum.
        program_grid(0, 0, 0, 127);
        send_item(make_request(vfga_pkg::OP_ADD, 500, 10, 255, -1));
        send_item(make_request(vfga_pkg::OP_READ, 32767, 32767, 0, 0));
        wait_idle();
        program_grid(0, 0, 100, 1);
        send_item(make_request(vfga_pkg::OP_READ, 63, 0, 0, 0));
        send_item(make_request(vfga_pkg::OP_ADD, 40, 5, 1, 1));
        wait_idle();
    endtask

    task automatic test_clear();
        send_item(make_request(vfga_pkg::OP_CLEAR, 32767, -1, -1, -32768));
        send_item(make_request(vfga_pkg::OP_READ, 40, 0, 0, 0));
        send_item(make_request(vfga_pkg::OP_ADD, 40, 0, 256, 256));
        send_item(make_request(vfga_pkg::OP_CLEAR, 0, 0, 0, 0));
        send_item(make_request(vfga_pkg::OP_READ, 40, 0, 0, 0));
        wait_idle();
    endtask

    // A one-cell grid driven hard in one direction so both components clip, then back.
    task automatic test_saturation();
        int ax;
        int ay;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        program_grid(1023, 1023, 1, 1);
        for (int i = 0; i < 320; i++) begin
            if ($urandom_range(0, 99) < 5) begin
                send_item(make_request($urandom_range(0, 1) ? vfga_pkg::OP_READ : OP_UNUSED,
                                       int'($urandom_range(0, 65535)) - 32768,
                                       int'($urandom_range(0, 65535)) - 32768, 0, 0));
            end else begin
                ax = 32767 - int'($urandom_range(0, 1000));
                ay = -32768 + int'($urandom_range(0, 1000));
                if (i >= 300) begin
                    ax = -ax;
                    ay = -ay - 1;
                end
                send_item(make_request(vfga_pkg::OP_ADD,
                                       int'($urandom_range(0, 65535)) - 32768,
                                       int'($urandom_range(0, 65535)) - 32768, ax, ay));
            end
        end
        wait_idle();
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 83;
        recv_stall_pct = 0;
        program_grid($urandom_range(1, 40), $urandom_range(1, 40),
                     $urandom_range(1, 8), $urandom_range(1, 8));
        repeat (70) send_item(random_request(2));
        wait_idle();
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        recv_stall_pct = 83;
        program_grid(1, 1023, 64, $urandom_range(1, 4));
        repeat (70) send_item(random_request(2));
        wait_idle();
    endtask

    task automatic test_both_idle();
        send_idle_pct = 20;
        recv_stall_pct = 20;
        program_grid($urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 127), $urandom_range(0, 127));
        repeat (70) send_item(random_request(2));
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        program_grid($urandom_range(1, 8), $urandom_range(1, 8),
                     $urandom_range(2, 4), $urandom_range(2, 4));
        -> hold_off_ev;
        repeat (20) send_item(random_request(0));
        wait_idle();
    endtask

    // Long receiver hold-off, timed here so the sender keeps offering requests meanwhile.
    initial forever begin
        @(hold_off_ev);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    always @(posedge clk) begin
        pop <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: %p", result_out);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("cell_column", want.cell_column, result_out.cell_column);
                compare_field("cell_row", want.cell_row, result_out.cell_row);
                compare_field("vector_x", want.vector_x, result_out.vector_x);
                compare_field("vector_y", want.vector_y, result_out.vector_y);
                compare_field("saturated", want.saturated, result_out.saturated);
            end
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_point_mapping();
        test_clear();
        test_saturation();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/vfga_pkg.sv
sv/vfga_front.sv
sv/vfga_queue.sv
sv/vfga_back.sv
sv/vector_field_grid_accumulator_unit.sv
sv/vfga_checker.sv
tb/testbench.sv
